@@ sv/lnpu_pkg.sv @@
`default_nettype none
package lnpu_pkg;

  // Field widths
  localparam int IDX_W   = 10;
  localparam int TIME_W  = 32;
  localparam int POT_W   = 16;
  localparam int CNT_W   = 11;
  localparam int PSUM_W  = 26;
  localparam int TDATA_W = 64;

  // Default population size
  localparam int NEURONS_DEF = 1024;

  // Register reset values
  localparam logic signed [POT_W-1:0] REST_RESET   = 16'shBA00;  // -70 mV
  localparam logic signed [POT_W-1:0] THRESH_RESET = 16'shCE00;  // -50 mV
  localparam logic        [15:0]      REFR_RESET   = 16'h051F;   // 0.02 s

  // Saturation limits
  localparam logic [CNT_W-1:0]         SPIKE_MAX = {CNT_W{1'b1}};
  localparam logic signed [PSUM_W-1:0] PSUM_MAX  = {1'b0, {(PSUM_W-1){1'b1}}};
  localparam logic signed [PSUM_W-1:0] PSUM_MIN  = {1'b1, {(PSUM_W-1){1'b0}}};
  localparam logic signed [POT_W-1:0]  POT_MAX   = 16'sh7FFF;
  localparam logic signed [POT_W-1:0]  POT_MIN   = 16'sh8000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_REST   = 2'd0,
    CFG_THRESH = 2'd1,
    CFG_REFR   = 2'd2
  } cfg_idx_t;

  // Configuration values
  typedef struct packed {
    logic signed [POT_W-1:0] rest;
    logic signed [POT_W-1:0] thresh;
    logic        [15:0]      refr_len;
  } cfg_t;

  // Per-neuron state word
  typedef struct packed {
    logic signed [POT_W-1:0] membrane;
    logic        [TIME_W-1:0] stamp;
    logic        [15:0]      refr_left;
  } nstate_t;

  // One input item
  typedef struct packed {
    logic        [IDX_W-1:0]  given;
    logic        [TIME_W-1:0] now;
    logic signed [POT_W-1:0]  psp;
    logic                     eos;
  } item_t;

  // Per-neuron part of a result
  typedef struct packed {
    logic        [IDX_W-1:0] neuron_out;
    logic                    spiked;
    logic signed [POT_W-1:0] potential;
    logic                    last;
  } result_t;

  // Pipeline load strobes
  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic out_load;
  } ctrl_t;

  // Saturate a 17 bit signed sum to 16 bits
  function automatic logic signed [POT_W-1:0] sat17(input logic signed [POT_W:0] s);
    logic signed [POT_W-1:0] r;
    if (s[POT_W] != s[POT_W-1]) begin
      r = s[POT_W] ? POT_MIN : POT_MAX;
    end else begin
      r = s[POT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/lnpu_state_ram.sv @@
`default_nettype none
module lnpu_state_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire                    clk,
  input  wire                    we,
  input  wire [ADDR_W-1:0]       waddr,
  input  lnpu_pkg::nstate_t      wdata,
  input  wire                    re,
  input  wire [ADDR_W-1:0]       raddr,
  output lnpu_pkg::nstate_t      rdata
);
  import lnpu_pkg::*;

  nstate_t mem [DEPTH];
  nstate_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/lnpu_datapath.sv @@
`default_nettype none
module lnpu_datapath #(
  parameter int ADDR_W = 10
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  lnpu_pkg::cfg_t         cfg,
  input  lnpu_pkg::ctrl_t        ctrl,
  input  lnpu_pkg::item_t        in_item,
  input  wire [ADDR_W-1:0]       in_addr,
  input  lnpu_pkg::nstate_t      rd_state,
  output logic [ADDR_W-1:0]      s1_addr,
  output logic [ADDR_W-1:0]      s2_addr,
  output lnpu_pkg::nstate_t      wr_state,
  output lnpu_pkg::result_t      s2_res
);
  import lnpu_pkg::*;

  // Stage 1 context
  item_t             s1_item_r;
  logic [ADDR_W-1:0] s1_addr_r;

  // Stage 2 context
  item_t                    s2_item_r;
  logic [ADDR_W-1:0]        s2_addr_r;
  logic signed [49:0]       s2_prod_r;
  logic signed [POT_W-1:0]  s2_v1_r;
  logic [15:0]              s2_left_r;

  // Last write-back, for forwarding
  logic                     wb_valid_r;
  logic [ADDR_W-1:0]        wb_addr_r;
  nstate_t                  wb_state_r;

  // Stage 1 signals
  nstate_t                  cur;
  logic [TIME_W-1:0]        dt;
  logic signed [POT_W:0]    in_sum;
  logic signed [POT_W-1:0]  v1;
  logic [15:0]              left1;
  logic signed [POT_W:0]    diff;
  logic signed [49:0]       prod;

  // Stage 2 signals
  logic signed [33:0]       leak;
  logic signed [34:0]       v_sum;
  logic signed [POT_W-1:0]  v_leak;
  logic                     fire;
  logic signed [POT_W-1:0]  v_new;
  logic [15:0]              left_new;

  // Capture the item that enters stage 1
  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      s1_item_r <= in_item;
      s1_addr_r <= in_addr;
    end
  end

  // Stage 1: forward, integrate input, count down, multiply
  always_comb begin
    cur = rd_state;
    if (wb_valid_r && (wb_addr_r == s1_addr_r)) begin
      cur = wb_state_r;
    end
    dt = s1_item_r.now - cur.stamp;
    in_sum = {cur.membrane[POT_W-1], cur.membrane} + {s1_item_r.psp[POT_W-1], s1_item_r.psp};
    v1 = (cur.refr_left == 16'd0) ? sat17(in_sum) : cur.membrane;
    if ({16'd0, cur.refr_left} > dt) begin
      left1 = cur.refr_left - dt[15:0];
    end else begin
      left1 = 16'd0;
    end
    diff = {cfg.rest[POT_W-1], cfg.rest} - {v1[POT_W-1], v1};
    prod = 50'($signed({1'b0, dt})) * 50'(diff);
  end

  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      s2_item_r <= s1_item_r;
      s2_addr_r <= s1_addr_r;
      s2_prod_r <= prod;
      s2_v1_r   <= v1;
      s2_left_r <= left1;
    end
  end

  // Stage 2: floor shift, leak, saturate, fire
  always_comb begin
    leak  = s2_prod_r[49:16];
    v_sum = {{19{s2_v1_r[POT_W-1]}}, s2_v1_r} + {leak[33], leak};
    if (v_sum > 35'sd32767) begin
      v_leak = POT_MAX;
    end else if (v_sum < -35'sd32768) begin
      v_leak = POT_MIN;
    end else begin
      v_leak = v_sum[POT_W-1:0];
    end
    fire     = v_leak > cfg.thresh;
    v_new    = fire ? cfg.rest : v_leak;
    left_new = fire ? cfg.refr_len : s2_left_r;
  end

  assign wr_state = '{membrane: v_new, stamp: s2_item_r.now, refr_left: left_new};
  assign s2_res   = '{neuron_out: s2_item_r.given, spiked: fire, potential: v_new,
                      last: s2_item_r.eos};

  // Keep a copy of the newest write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      wb_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      wb_addr_r  <= s2_addr_r;
      wb_state_r <= wr_state;
    end
  end

  assign s1_addr = s1_addr_r;
  assign s2_addr = s2_addr_r;

endmodule
`default_nettype wire

@@ sv/lnpu_tally.sv @@
`default_nettype none
module lnpu_tally (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   load,
  input  lnpu_pkg::result_t                     res,
  output lnpu_pkg::result_t                     out_res,
  output logic [lnpu_pkg::CNT_W-1:0]            out_spikes,
  output logic signed [lnpu_pkg::PSUM_W-1:0]    out_psum
);
  import lnpu_pkg::*;

  logic [CNT_W-1:0]          spike_r;
  logic [CNT_W-1:0]          spike_nxt;
  logic signed [PSUM_W-1:0]  psum_r;
  logic signed [PSUM_W-1:0]  psum_nxt;
  logic signed [PSUM_W:0]    psum_wide;

  result_t                   res_r;
  logic [CNT_W-1:0]          spikes_out_r;
  logic signed [PSUM_W-1:0]  psum_out_r;

  // Add this update to the running tallies, saturating
  always_comb begin
    spike_nxt = spike_r;
    if (res.spiked && (spike_r != SPIKE_MAX)) begin
      spike_nxt = spike_r + 1'b1;
    end
    psum_wide = {psum_r[PSUM_W-1], psum_r} +
                {{(PSUM_W-POT_W+1){res.potential[POT_W-1]}}, res.potential};
    if (psum_wide[PSUM_W] != psum_wide[PSUM_W-1]) begin
      psum_nxt = psum_wide[PSUM_W] ? PSUM_MIN : PSUM_MAX;
    end else begin
      psum_nxt = psum_wide[PSUM_W-1:0];
    end
  end

  // Tallies clear after the last beat of a step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spike_r <= '0;
      psum_r  <= '0;
    end else if (load) begin
      spike_r <= res.last ? '0 : spike_nxt;
      psum_r  <= res.last ? '0 : psum_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      res_r        <= res;
      spikes_out_r <= spike_nxt;
      psum_out_r   <= psum_nxt;
    end
  end

  assign out_res    = res_r;
  assign out_spikes = spikes_out_r;
  assign out_psum   = psum_out_r;

endmodule
`default_nettype wire

@@ sv/lif_neuron_population_update_unit.sv @@
`default_nettype none
// Leaky integrate-and-fire population update, one neuron per input beat.
// Input beat (in_*): neuron index, time stamp and synaptic input in tdata,
// end of time step in tlast. Result beat (out_*): neuron index, spike flag,
// new potential and the running spike and potential tallies of the step in
// tdata, end of step echoed in tlast. Configuration (cfg_*): one write per
// beat, register index 0 rest potential, 1 threshold, 2 refractory length;
// other indexes are ignored. cfg_ready is always high; write only when idle.
// A result passes the stage 1, stage 2 and output registers in turn.
// Throughput: one beat per cycle unless a hazard or output stall holds it.
// The state memory is read as a beat is accepted, ahead of stage 1, and
// written from the last stage; a beat that hits the same neuron as the beat
// in stage 1, or in a stalled stage 2, waits until that beat moves on.
// Reset: after rst_n rises, a clearing pass writes the reset state into all
// NEURONS entries, one per cycle, with in_tready low.
// Stall: the output register holds a result until taken; two more beats
// can be accepted into the pipeline behind it before in_tready drops.
module lif_neuron_population_update_unit #(
  parameter int NEURONS = lnpu_pkg::NEURONS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // neuron[9:0], now[41:10], psp_sum[57:42], zero[63:58]
  input  wire [lnpu_pkg::TDATA_W-1:0]  in_tdata,
  input  wire                          in_tlast,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // neuron_out[9:0], spiked[10], potential[26:11], step_spikes[37:27],
  // step_potential_sum[63:38]
  output logic [lnpu_pkg::TDATA_W-1:0] out_tdata,
  output logic                         out_tlast,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [1:0]                    cfg_index,
  input  wire [15:0]                   cfg_data
);
  import lnpu_pkg::*;

  localparam int ADDR_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NEURONS - 1);

  // Configuration registers
  cfg_t cfg_r;

  // Control state
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              s1_valid_r;
  logic              s2_valid_r;
  logic              out_valid_r;

  item_t             in_item;
  logic [IDX_W-1:0]  idx_red;
  logic [EXT_W-1:0]  idx_ext;
  logic [ADDR_W-1:0] in_addr;
  logic              out_free;
  logic              s1_adv;
  logic              hazard;
  logic              accept;
  ctrl_t             ctrl;

  logic [ADDR_W-1:0] s1_addr;
  logic [ADDR_W-1:0] s2_addr;
  nstate_t           rd_state;
  nstate_t           wr_state;
  nstate_t           mem_wdata;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_we;
  result_t           s2_res;
  result_t           out_res;
  logic [CNT_W-1:0]  out_spikes;
  logic signed [PSUM_W-1:0] out_psum;

  // Unpack the input beat
  assign in_item = '{given: in_tdata[9:0], now: in_tdata[41:10],
                     psp: in_tdata[57:42], eos: in_tlast};

  // Reduce the index into the population by conditional subtraction
  always_comb begin
    idx_red = in_item.given;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if ((NEURONS << k) < (1 << IDX_W)) begin
        if (idx_red >= IDX_W'(NEURONS << k)) begin
          idx_red = idx_red - IDX_W'(NEURONS << k);
        end
      end
    end
    idx_ext = EXT_W'(idx_red);
  end
  assign in_addr = idx_ext[ADDR_W-1:0];

  // Handshake and pipeline advance
  always_comb begin
    out_free = !out_valid_r || out_tready;
    s1_adv   = !s2_valid_r || out_free;
    hazard   = (s1_valid_r && (s1_addr == in_addr)) ||
               (s2_valid_r && (s2_addr == in_addr) && !out_free);
    in_tready = !clearing_r && (!s1_valid_r || s1_adv) && !hazard;
    accept    = in_tvalid && in_tready;
    ctrl.s1_load  = accept;
    ctrl.s2_load  = s1_valid_r && s1_adv;
    ctrl.out_load = s2_valid_r && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Clearing pass over the state memory after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest     <= REST_RESET;
      cfg_r.thresh   <= THRESH_RESET;
      cfg_r.refr_len <= REFR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REST:   cfg_r.rest     <= cfg_data;
        CFG_THRESH: cfg_r.thresh   <= cfg_data;
        CFG_REFR:   cfg_r.refr_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memory write: clearing pass or write-back
  always_comb begin
    mem_we = clearing_r || ctrl.out_load;
    if (clearing_r) begin
      mem_waddr = clr_cnt_r;
      mem_wdata = '{membrane: REST_RESET, stamp: '0, refr_left: '0};
    end else begin
      mem_waddr = s2_addr;
      mem_wdata = wr_state;
    end
  end

  lnpu_state_ram #(
    .DEPTH  (NEURONS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (rd_state)
  );

  lnpu_datapath #(
    .ADDR_W (ADDR_W)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .ctrl     (ctrl),
    .in_item  (in_item),
    .in_addr  (in_addr),
    .rd_state (rd_state),
    .s1_addr  (s1_addr),
    .s2_addr  (s2_addr),
    .wr_state (wr_state),
    .s2_res   (s2_res)
  );

  lnpu_tally u_tally (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ctrl.out_load),
    .res        (s2_res),
    .out_res    (out_res),
    .out_spikes (out_spikes),
    .out_psum   (out_psum)
  );

  // Pack the result beat
  assign out_tdata  = {out_psum, out_spikes, out_res.potential, out_res.spiked,
                       out_res.neuron_out};
  assign out_tlast  = out_res.last;
  assign out_tvalid = out_valid_r;

  // No pipeline write-back may collide with the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !ctrl.out_load && !s1_valid_r && !out_valid_r)
    else $error("pipeline active during clearing pass");

  // Interlock keeps the two stages on different neurons
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r) |-> (s1_addr != s2_addr))
    else $error("same neuron in both pipeline stages");

  // An accepted beat reaches stage 2 once the path ahead is free
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_valid_r) |=> s2_valid_r)
    else $error("stage 1 beat did not advance");

endmodule
`default_nettype wire

@@ test/lif_neuron_population_update_unit_test.sv @@
`default_nettype none
module lif_neuron_population_update_unit_test;
  import lnpu_pkg::*;

  localparam int NEURONS = 1024;
  localparam longint TALLY_HI = 33554431;
  localparam longint TALLY_LO = -33554432;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Idle patterns for the two stream sides
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct packed {
    logic        [9:0]  neuron;
    logic               spiked;
    logic signed [15:0] potential;
    logic        [10:0] spikes;
    logic signed [25:0] pot_sum;
    logic               last;
  } neuron_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [63:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow of the population state and the registers
  logic signed [15:0] membrane_mem [NEURONS];
  logic        [31:0] stamp_mem [NEURONS];
  logic        [15:0] refr_mem [NEURONS];
  logic        [10:0] spike_cnt;
  longint             pot_acc;
  logic signed [15:0] rest_q;
  logic signed [15:0] thr_q;
  logic        [15:0] refr_q;

  item_t          updates_to_send [$];
  neuron_result_t predicted_updates [$];
  item_t          cur_beat;
  bit             beat_taken = 1'b0;
  int             idle_mode = IDLE_NONE;
  int             errors = 0;

  lif_neuron_population_update_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("lif_neuron_population_update_unit_test: FAIL");
    $finish;
  end

  function automatic longint clip16(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // Advance one neuron and the step tallies, return the expected result beat
  function automatic neuron_result_t update_neuron(input item_t it);
    logic [9:0]     n;
    logic [31:0]    dt;
    logic [15:0]    left;
    longint         v;
    longint         dt_l;
    longint         rest_l;
    longint         thr_l;
    longint         psp_l;
    longint         leak;
    bit             fired;
    neuron_result_t r;
    n = 10'(it.given % NEURONS);
    dt = it.now - stamp_mem[n];
    v = membrane_mem[n];
    left = refr_mem[n];
    dt_l = dt;
    rest_l = rest_q;
    thr_l = thr_q;
    psp_l = it.psp;
    stamp_mem[n] = it.now;
    // add input only outside the refractory period, else count it down
    if (left == 0) begin
      v = clip16(v + psp_l);
    end else if (left > dt) begin
      left = left - dt[15:0];
    end else begin
      left = '0;
    end
    leak = (dt_l * (rest_l - v)) >>> 16;
    v = clip16(v + leak);
    fired = (v > thr_l);
    if (fired) begin
      v = rest_l;
      left = refr_q;
    end
    membrane_mem[n] = v[15:0];
    refr_mem[n] = left;
    if (fired && spike_cnt != SPIKE_MAX) spike_cnt = spike_cnt + 1'b1;
    pot_acc = pot_acc + v;
    if (pot_acc > TALLY_HI) pot_acc = TALLY_HI;
    if (pot_acc < TALLY_LO) pot_acc = TALLY_LO;
    r.neuron = it.given;
    r.spiked = fired;
    r.potential = v[15:0];
    r.spikes = spike_cnt;
    r.pot_sum = pot_acc[25:0];
    r.last = it.eos;
    if (it.eos) begin
      spike_cnt = '0;
      pot_acc = 0;
    end
    return r;
  endfunction

  function automatic bit coin(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
    end
  endtask

  // Drive the input stream: hold a beat until taken, then maybe idle
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || beat_taken)) begin
      if (updates_to_send.size() != 0 &&
          !((idle_mode == IDLE_SEND && coin(82)) || (idle_mode == IDLE_BOTH && coin(33)))) begin
        cur_beat = updates_to_send.pop_front();
        in_tdata <= {6'd0, cur_beat.psp, cur_beat.now, cur_beat.given};
        in_tlast <= cur_beat.eos;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    beat_taken = 1'b0;
    out_tready <= !((idle_mode == IDLE_RECV && coin(82)) || (idle_mode == IDLE_BOTH && coin(33)));
  end

  // Sample all handshakes; check results before new predictions are queued
  always @(posedge clk) begin
    neuron_result_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (predicted_updates.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none actual %h", $time, out_tdata);
        end else begin
          exp_r = predicted_updates.pop_front();
          check_field("neuron_out", 32'(exp_r.neuron), 32'(out_tdata[9:0]));
          check_field("spiked", 32'(exp_r.spiked), 32'(out_tdata[10]));
          check_field("potential", 32'($unsigned(exp_r.potential)), 32'(out_tdata[26:11]));
          check_field("step_spikes", 32'(exp_r.spikes), 32'(out_tdata[37:27]));
          check_field("step_potential_sum", 32'($unsigned(exp_r.pot_sum)),
                      32'(out_tdata[63:38]));
          check_field("last", 32'(exp_r.last), 32'(out_tlast));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REST:   rest_q = cfg_data;
          CFG_THRESH: thr_q = cfg_data;
          CFG_REFR:   refr_q = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predicted_updates.push_back(update_neuron(cur_beat));
        beat_taken = 1'b1;
      end
    end
  end

  task automatic queue_update(input logic [9:0] nrn, input logic [31:0] t,
                              input logic [15:0] psp, input logic eos);
    item_t it;
    it.given = nrn;
    it.now = t;
    it.psp = psp;
    it.eos = eos;
    updates_to_send.push_back(it);
  endtask

  task automatic wait_idle();
    while (updates_to_send.size() != 0 || predicted_updates.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [9:0]  nrn;
    logic [31:0] t;
    logic [15:0] psp;
    int          r;
    int          rest_i;
    int          thr_i;
    for (int i = 0; i < NEURONS; i++) begin
      membrane_mem[i] = REST_RESET;
      stamp_mem[i] = '0;
      refr_mem[i] = '0;
    end
    spike_cnt = '0;
    pot_acc = 0;
    rest_q = REST_RESET;
    thr_q = THRESH_RESET;
    refr_q = REFR_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats with the reset register values
    queue_update(10'd0, 32'd0, 16'd0, 1'b0);
    queue_update(10'd1023, 32'd100, 16'h7FFF, 1'b0);     // large input, fire
    queue_update(10'd1023, 32'd200, 16'd1000, 1'b0);     // back to back, refractory
    queue_update(10'd1023, 32'hFFFF_FFFF, 16'd0, 1'b0);  // huge dt
    queue_update(10'd1023, 32'd5, 16'd300, 1'b0);        // time runs backwards
    queue_update(10'd2, 32'd10, 16'h8000, 1'b0);         // saturate down
    queue_update(10'd2, 32'd11, 16'h8000, 1'b0);
    queue_update(10'd3, 32'd0, 16'd5200, 1'b0);          // just above threshold
    queue_update(10'd4, 32'd0, 16'd5120, 1'b0);          // exactly at threshold
    queue_update(10'd5, 32'd65536, 16'd1000, 1'b1);      // full leak, end of step
    queue_update(10'd5, 32'd65600, 16'd6000, 1'b0);
    queue_update(10'h2AA, 32'hAAAA_AAAA, 16'h5555, 1'b0);
    queue_update(10'h155, 32'h5555_5555, 16'hAAAA, 1'b0);
    queue_update(10'h155, 32'h5555_5600, 16'h0100, 1'b0);
    queue_update(10'h2AA, 32'hAAAA_AB00, 16'hFF00, 1'b1);
    queue_update(10'd6, 32'd1000, 16'd2500, 1'b0);
    queue_update(10'd6, 32'd1000, 16'd2500, 1'b0);
    queue_update(10'd6, 32'd1001, 16'd2500, 1'b1);
    wait_idle();

    // Random batches across idle patterns and register settings
    nrn = '0;
    t = 32'd2000;
    for (int p = 0; p < 8; p++) begin
      idle_mode = p % 4;
      if (p == 4) begin
        write_reg(CFG_REST, REST_RESET);
        write_reg(CFG_THRESH, THRESH_RESET);
        write_reg(CFG_REFR, REFR_RESET);
      end else if (p != 0) begin
        rest_i = int'($urandom_range(17000)) - 25000;
        thr_i = rest_i + int'($urandom_range(9000));
        write_reg(CFG_REST, 16'(rest_i));
        write_reg(CFG_THRESH, 16'(thr_i));
        write_reg(CFG_REFR, 16'($urandom_range(4000)));
        write_reg(CFG_UNUSED, 16'($urandom));
      end
      for (int i = 0; i < 50; i++) begin
        // mostly a small neuron set so updates pile up; sometimes repeat one
        r = $urandom_range(99);
        if (r < 70) nrn = 10'($urandom_range(15));
        else if (r < 88) nrn = 10'($urandom_range(1023));
        r = $urandom_range(99);
        if (r < 90) t = t + $urandom_range(400);
        else if (r < 95) t = t + $urandom;
        else t = t - $urandom_range(5000);
        if (coin(80)) psp = 16'(int'($urandom_range(4000)) - 1000);
        else psp = 16'($urandom);
        queue_update(nrn, t, psp, ($urandom_range(23) == 0));
      end
      wait_idle();
    end

    // High extremes: nearly every update fires
    idle_mode = IDLE_NONE;
    write_reg(CFG_REST, POT_MAX);
    write_reg(CFG_THRESH, POT_MIN);
    write_reg(CFG_REFR, 16'hFFFF);
    for (int i = 0; i < 100; i++) begin
      t = t + $urandom_range(50);
      queue_update(10'($urandom_range(255)), t, 16'($urandom_range(2000)), (i == 99));
    end
    wait_idle();

    // Low extremes: no firing, potential tally runs far negative
    write_reg(CFG_REST, POT_MIN);
    write_reg(CFG_THRESH, POT_MAX);
    write_reg(CFG_REFR, 16'h0000);
    for (int i = 0; i < 80; i++) begin
      t = t + $urandom_range(50);
      queue_update(10'($urandom_range(63)), t, 16'h8000 | 16'($urandom_range(15)),
                   (i == 79));
    end
    wait_idle();

    // Drain and let any stray beat show up
    idle_mode = IDLE_BOTH;
    repeat (20) @(posedge clk);
    if (predicted_updates.size() != 0) begin
      errors++;
      $display("%0t: results missing, expected %0d actual 0", $time, predicted_updates.size());
    end
    if (errors == 0) begin
      $display("lif_neuron_population_update_unit_test: PASS");
    end else begin
      $display("lif_neuron_population_update_unit_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ lif_neuron_population_update_unit.f @@
sv/lnpu_pkg.sv
sv/lnpu_state_ram.sv
sv/lnpu_datapath.sv
sv/lnpu_tally.sv
sv/lif_neuron_population_update_unit.sv
test/lif_neuron_population_update_unit_test.sv
